[rtl/core/tpa_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle primitive assembly package
// Shared types, field widths and codes for the triangle primitive assembly
// unit.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int VTX_W   = 17;
    localparam int POS_W   = 16;
    localparam int CNT_W   = 16;
    localparam int VCNT_W  = 21;
    localparam int ICNT_W  = 25;
    localparam int PCNT_W  = 21;
    localparam int KIND_W  = 3;

    localparam int TPA_MID_DEPTH = 4;

    localparam logic [KIND_W-1:0] PRIM_LIST  = 3'd4;
    localparam logic [KIND_W-1:0] PRIM_STRIP = 3'd5;
    localparam logic [KIND_W-1:0] PRIM_FAN   = 3'd6;

    localparam logic [1:0] KIND_LIST  = 2'd0;
    localparam logic [1:0] KIND_STRIP = 2'd1;
    localparam logic [1:0] KIND_FAN   = 2'd2;

    localparam logic [1:0] PHASE_LAST = 2'd2;

    localparam logic [CNT_W-1:0] MIN_COUNT = 16'd3;
    localparam logic [CNT_W-1:0] POS_MAX   = 16'hFFFF;

    localparam logic [1:0] REG_VERTEX_COUNT   = 2'd0;
    localparam logic [1:0] REG_INDEX_COUNT    = 2'd1;
    localparam logic [1:0] REG_POSITION_COUNT = 2'd2;

    typedef struct packed {
        logic [VTX_W-1:0] vtx_a;
        logic [VTX_W-1:0] vtx_b;
        logic [VTX_W-1:0] vtx_c;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic [POS_W-1:0] pos_c;
    } tpa_cand_t;

endpackage

[rtl/core/tpa_front.sv]
// ----------------------------------------------------------------------------
// Triangle assembly front end
// Accepts one vertex per transaction, tracks the primitive state and emits a
// candidate triangle with its corner positions.
// ----------------------------------------------------------------------------
module tpa_front
    import tpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                first,
    input  logic [KIND_W-1:0]   prim_kind,
    input  logic                indexed,
    input  logic [CNT_W-1:0]    prim_start,
    input  logic [CNT_W-1:0]    prim_count,
    input  logic [VTX_W-1:0]    vertex_index,
    input  logic [POS_W-1:0]    position_index,
    input  logic [VCNT_W-1:0]   vertex_count,
    input  logic [ICNT_W-1:0]   index_count,
    output logic                cand_push,
    output tpa_cand_t           cand
);

    logic [VTX_W-1:0] fan_vtx_reg, older_vtx_reg, newer_vtx_reg;
    logic [POS_W-1:0] fan_pos_reg, older_pos_reg, newer_pos_reg;
    logic             fan_bad_reg, older_bad_reg, newer_bad_reg;
    logic [CNT_W-1:0] vpos_reg, vpos_next;
    logic [1:0]       phase_reg, phase_next;
    logic             skip_reg, skip_next;
    logic [1:0]       kind_reg, kind_next;

    logic              bad;
    logic [ICNT_W-1:0] limit;
    logic [CNT_W:0]    span;
    logic              kind_ok;
    logic [CNT_W-1:0]  p;
    logic [1:0]        phase;
    logic              form;
    logic              any_bad;

    always_comb
    begin
        bad     = {{(VCNT_W-VTX_W){1'b0}}, vertex_index} >= vertex_count;
        limit   = indexed ? index_count : {{(ICNT_W-VCNT_W){1'b0}}, vertex_count};
        span    = {1'b0, prim_start} + {1'b0, prim_count};
        kind_ok = (prim_kind == PRIM_LIST) || (prim_kind == PRIM_STRIP) ||
                  (prim_kind == PRIM_FAN);
        if (first)
        begin
            skip_next = !kind_ok || (prim_count < MIN_COUNT) ||
                        ({{(ICNT_W-CNT_W-1){1'b0}}, span} > limit);
            kind_next = kind_ok ? 2'(prim_kind - PRIM_LIST) : KIND_LIST;
            p         = '0;
            phase     = '0;
        end
        else
        begin
            skip_next = skip_reg;
            kind_next = kind_reg;
            p         = vpos_reg;
            phase     = (phase_reg > PHASE_LAST) ? 2'd0 : phase_reg;
        end

        form = 1'b1;
        case (kind_next)
            KIND_LIST:
            begin
                form       = (phase == PHASE_LAST);
                cand.vtx_a = older_vtx_reg;
                cand.vtx_b = vertex_index;
                cand.vtx_c = newer_vtx_reg;
                cand.pos_a = older_pos_reg;
                cand.pos_b = position_index;
                cand.pos_c = newer_pos_reg;
                any_bad    = older_bad_reg || bad || newer_bad_reg;
            end
            KIND_STRIP:
            begin
                cand.vtx_a = older_vtx_reg;
                cand.pos_a = older_pos_reg;
                if (p[0])
                begin
                    cand.vtx_b = vertex_index;
                    cand.pos_b = position_index;
                    cand.vtx_c = newer_vtx_reg;
                    cand.pos_c = newer_pos_reg;
                end
                else
                begin
                    cand.vtx_b = newer_vtx_reg;
                    cand.pos_b = newer_pos_reg;
                    cand.vtx_c = vertex_index;
                    cand.pos_c = position_index;
                end
                any_bad = older_bad_reg || bad || newer_bad_reg;
            end
            default:
            begin
                cand.vtx_a = fan_vtx_reg;
                cand.vtx_b = newer_vtx_reg;
                cand.vtx_c = vertex_index;
                cand.pos_a = fan_pos_reg;
                cand.pos_b = newer_pos_reg;
                cand.pos_c = position_index;
                any_bad    = fan_bad_reg || bad || newer_bad_reg;
            end
        endcase

        cand_push  = accept && !skip_next && (p >= 16'd2) && (p < prim_count) &&
                     form && !any_bad;
        vpos_next  = (p < POS_MAX) ? p + 16'd1 : POS_MAX;
        phase_next = (phase == PHASE_LAST) ? 2'd0 : phase + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_vtx_reg   <= '0;
            fan_pos_reg   <= '0;
            fan_bad_reg   <= 1'b0;
            older_vtx_reg <= '0;
            older_pos_reg <= '0;
            older_bad_reg <= 1'b0;
            newer_vtx_reg <= '0;
            newer_pos_reg <= '0;
            newer_bad_reg <= 1'b0;
            vpos_reg      <= '0;
            phase_reg     <= '0;
            skip_reg      <= 1'b1;
            kind_reg      <= KIND_LIST;
        end
        else if (accept)
        begin
            if (p == '0)
            begin
                fan_vtx_reg <= vertex_index;
                fan_pos_reg <= position_index;
                fan_bad_reg <= bad;
            end
            older_vtx_reg <= newer_vtx_reg;
            older_pos_reg <= newer_pos_reg;
            older_bad_reg <= newer_bad_reg;
            newer_vtx_reg <= vertex_index;
            newer_pos_reg <= position_index;
            newer_bad_reg <= bad;
            vpos_reg      <= vpos_next;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            kind_reg      <= kind_next;
        end
    end

endmodule

[rtl/core/tpa_queue.sv]
// ----------------------------------------------------------------------------
// Candidate triangle queue
// Short first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module tpa_queue
    import tpa_pkg::*;
#(
    parameter int DEPTH = TPA_MID_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  tpa_cand_t wr_data,
    input  logic      rd_en,
    output tpa_cand_t rd_data,
    output logic      q_full,
    output logic      q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    tpa_cand_t        mem [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    always_comb
    begin
        do_wr      = wr_en && !q_full;
        do_rd      = rd_en && !q_empty;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign q_full  = (count_reg == DEPTH_CNT);
    assign q_empty = (count_reg == '0);
    assign rd_data = mem[head_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[tail_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/tpa_back.sv]
// ----------------------------------------------------------------------------
// Triangle assembly back end
// Drops degenerate triangles and triangles with out-of-range positions and
// holds the surviving triangle in the output register.
// ----------------------------------------------------------------------------
module tpa_back
    import tpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  tpa_cand_t          q_data,
    output logic               q_pop,
    input  logic [PCNT_W-1:0]  position_count,
    input  logic               pop,
    output logic               empty,
    output logic [VTX_W-1:0]   corner_a,
    output logic [VTX_W-1:0]   corner_b,
    output logic [VTX_W-1:0]   corner_c
);

    logic             valid_reg, valid_next;
    logic [VTX_W-1:0] a_reg, b_reg, c_reg;
    logic             keep;

    always_comb
    begin
        keep = (q_data.pos_a != q_data.pos_b) && (q_data.pos_b != q_data.pos_c) &&
               (q_data.pos_a != q_data.pos_c) &&
               ({{(PCNT_W-POS_W){1'b0}}, q_data.pos_a} < position_count) &&
               ({{(PCNT_W-POS_W){1'b0}}, q_data.pos_b} < position_count) &&
               ({{(PCNT_W-POS_W){1'b0}}, q_data.pos_c} < position_count);
        q_pop      = !q_empty && (!valid_reg || pop);
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = keep;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && keep)
        begin
            a_reg <= q_data.vtx_a;
            b_reg <= q_data.vtx_b;
            c_reg <= q_data.vtx_c;
        end
    end

    assign empty    = !valid_reg;
    assign corner_a = a_reg;
    assign corner_b = b_reg;
    assign corner_c = c_reg;

endmodule

[rtl/core/triangle_primitive_assembly_unit.sv]
// ----------------------------------------------------------------------------
// Triangle primitive assembly unit
// Builds triangles from list, strip and fan primitives, one vertex per
// transaction, and drops invalid primitives and triangles.
// ----------------------------------------------------------------------------
// The unit takes one vertex per clock cycle while full is low and returns at
// most one triangle per vertex, through the queue and the output register.
// A queue of MID_DEPTH candidates sits between the vertex front end and the
// triangle checks; full rises only when that queue is full, which happens
// when results are not popped. The user must write the mesh limits through
// the register port while no vertex is in flight; it is not enforced.
module triangle_primitive_assembly_unit
    import tpa_pkg::*;
#(
    parameter int MID_DEPTH = TPA_MID_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic                first,
    input  logic [KIND_W-1:0]   prim_kind,
    input  logic                indexed,
    input  logic [CNT_W-1:0]    prim_start,
    input  logic [CNT_W-1:0]    prim_count,
    input  logic [VTX_W-1:0]    vertex_index,
    input  logic [POS_W-1:0]    position_index,
    output logic                empty,
    input  logic                pop,
    output logic [VTX_W-1:0]    corner_a,
    output logic [VTX_W-1:0]    corner_b,
    output logic [VTX_W-1:0]    corner_c
);

    logic [VCNT_W-1:0] vertex_count_reg;
    logic [ICNT_W-1:0] index_count_reg;
    logic [PCNT_W-1:0] position_count_reg;
    logic              wr_access;

    logic      accept;
    logic      cand_push;
    tpa_cand_t cand;
    tpa_cand_t q_data;
    logic      q_empty;
    logic      q_pop;

    assign pready    = 1'b1;
    assign wr_access = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg   <= '0;
            index_count_reg    <= '0;
            position_count_reg <= '0;
        end
        else if (wr_access)
        begin
            case (paddr[3:2])
                REG_VERTEX_COUNT:   vertex_count_reg   <= pwdata[VCNT_W-1:0];
                REG_INDEX_COUNT:    index_count_reg    <= pwdata[ICNT_W-1:0];
                REG_POSITION_COUNT: position_count_reg <= pwdata[PCNT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_VERTEX_COUNT:   prdata = {{(32-VCNT_W){1'b0}}, vertex_count_reg};
            REG_INDEX_COUNT:    prdata = {{(32-ICNT_W){1'b0}}, index_count_reg};
            REG_POSITION_COUNT: prdata = {{(32-PCNT_W){1'b0}}, position_count_reg};
            default:            prdata = '0;
        endcase
    end

    assign accept = push && !full;

    tpa_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .first          (first),
        .prim_kind      (prim_kind),
        .indexed        (indexed),
        .prim_start     (prim_start),
        .prim_count     (prim_count),
        .vertex_index   (vertex_index),
        .position_index (position_index),
        .vertex_count   (vertex_count_reg),
        .index_count    (index_count_reg),
        .cand_push      (cand_push),
        .cand           (cand)
    );

    tpa_queue #(
        .DEPTH (MID_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cand_push),
        .wr_data (cand),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_full  (full),
        .q_empty (q_empty)
    );

    tpa_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .position_count (position_count_reg),
        .pop            (pop),
        .empty          (empty),
        .corner_a       (corner_a),
        .corner_b       (corner_b),
        .corner_c       (corner_c)
    );

endmodule

[rtl/core/tpa_checker.sv]
// ----------------------------------------------------------------------------
// Triangle assembly port checker
// Concurrent checks on the ports of the triangle primitive assembly unit.
// ----------------------------------------------------------------------------
module tpa_checker
    import tpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    input  logic              full,
    input  logic              empty,
    input  logic              pop,
    input  logic [VTX_W-1:0]  corner_a,
    input  logic [VTX_W-1:0]  corner_b,
    input  logic [VTX_W-1:0]  corner_c
);

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (empty && !full))
        else $error("queue not clear after reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result vanished");

    a_corners_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(corner_a) && $stable(corner_b) &&
                              $stable(corner_c)))
        else $error("waiting result changed");

    a_vertex_count_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr == {REG_VERTEX_COUNT, 2'b00}) |=>
        (!(psel && !pwrite && paddr == {REG_VERTEX_COUNT, 2'b00}) ||
         prdata[VCNT_W-1:0] == $past(pwdata[VCNT_W-1:0])))
        else $error("vertex count readback mismatch");

endmodule

bind triangle_primitive_assembly_unit tpa_checker u_tpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .corner_a (corner_a),
    .corner_b (corner_b),
    .corner_c (corner_c)
);
